/* rtl/nct_pkg.sv */
// ----------------------------------------------------------------------------
// nct_pkg: shared types and constants for the nested config tokenizer
// Parse modes, event codes, result bundle layout and escape translation.
// ----------------------------------------------------------------------------
package nct_pkg;

  localparam int MAX_NESTING     = 255;
  localparam int MAX_HELD_SPACES = 255;

  localparam int LVL_W  = $clog2(MAX_NESTING + 1);
  localparam int HELD_W = $clog2(MAX_HELD_SPACES + 1);

  // bundle queue, depth must be a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int MAX_EVENTS = 3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLLAPSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT     = 2'd2;

  localparam logic ERR_BRACE      = 1'b0;
  localparam logic ERR_INCOMPLETE = 1'b1;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_OPEN   = 8'h7B;
  localparam logic [7:0] CH_CLOSE  = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  typedef enum logic [2:0] {
    M_FIND_NAME  = 3'd0,
    M_READ_NAME  = 3'd1,
    M_FIND_VALUE = 3'd2,
    M_READ_VALUE = 3'd3,
    M_COMMENT    = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    EV_NAME_BYTE  = 3'd0,
    EV_VALUE_BYTE = 3'd1,
    EV_NAME_END   = 3'd2,
    EV_VALUE_END  = 3'd3,
    EV_NODE_BEGIN = 3'd4,
    EV_NODE_END   = 3'd5,
    EV_ERROR      = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] text;
    logic [7:0] spaces;
    logic       err;
  } evt_t;

  // all results of one input byte; count is 1..3
  typedef struct packed {
    logic [1:0]                count;
    evt_t [MAX_EVENTS-1:0]     ev;
  } bundle_t;

  function automatic evt_t ev_make(kind_t kind, logic [7:0] text, logic [7:0] spaces,
                                   logic err);
    evt_t e;
    e.kind   = kind;
    e.text   = text;
    e.spaces = spaces;
    e.err    = err;
    return e;
  endfunction

  function automatic logic [7:0] esc_translate(logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h6E:   r = 8'd10;  // n
      8'h72:   r = 8'd13;  // r
      8'h61:   r = 8'd7;   // a
      8'h62:   r = 8'd8;   // b
      8'h66:   r = 8'd12;  // f
      8'h74:   r = 8'd9;   // t
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

/* rtl/nct_if.sv */
// ----------------------------------------------------------------------------
// nct_if: valid/ready channels of the tokenizer
// Input byte channel and output event channel.
// ----------------------------------------------------------------------------
interface nct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_doc;

  modport source (output valid, output byte_in, output end_of_doc, input ready);
  modport sink   (input valid, input byte_in, input end_of_doc, output ready);
endinterface

interface nct_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] text_byte;
  logic [7:0] spaces_before;
  logic       error_code;
  logic       last_of_item;

  modport source (output valid, output event_kind, output text_byte, output spaces_before,
                  output error_code, output last_of_item, input ready);
  modport sink   (input valid, input event_kind, input text_byte, input spaces_before,
                  input error_code, input last_of_item, output ready);
endinterface

/* rtl/nct_front.sv */
// ----------------------------------------------------------------------------
// nct_front: byte classifier and parse state
// Takes one byte a cycle while the queue is not full, updates mode, nesting
// and held spaces, and pushes the byte's events as one bundle into the queue.
// ----------------------------------------------------------------------------
module nct_front
  import nct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  nct_in_if.sink                items,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_full,
  output logic                  q_push,
  output bundle_t               q_data
);

  logic              collapse, trim, root_ok;
  mode_t             mode, mode_next;
  logic              esc, esc_next;
  logic [7:0]        prev_byte, prev_byte_next;
  logic [LVL_W-1:0]  level, level_next;
  logic [HELD_W-1:0] held, held_next;
  logic              halted, halted_next;

  logic       accept;
  logic [1:0] n;
  evt_t [MAX_EVENTS-1:0] evs;
  logic [7:0] c;
  logic       do_text, do_close, go_comment;

  assign items.ready = !q_full;
  assign accept      = items.valid && items.ready;

  always_comb begin
    mode_next      = mode;
    esc_next       = esc;
    prev_byte_next = prev_byte;
    level_next     = level;
    held_next      = held;
    halted_next    = halted;
    n              = 2'd0;
    evs            = '0;
    c              = items.byte_in;
    do_text        = 1'b0;
    do_close       = 1'b0;
    go_comment     = 1'b0;

    if (items.end_of_doc) begin
      if (!halted) begin
        if (mode == M_READ_NAME) begin
          evs[n] = ev_make(EV_NAME_END, 8'd0, 8'd0, 1'b0);
          n = n + 2'd1;
          evs[n] = ev_make(EV_VALUE_END, 8'd0, 8'd0, 1'b0);
          n = n + 2'd1;
        end else if (mode == M_READ_VALUE) begin
          evs[n] = ev_make(EV_VALUE_END, 8'd0, 8'd0, 1'b0);
          n = n + 2'd1;
        end
        if (level != '0) begin
          evs[n] = ev_make(EV_ERROR, 8'd0, 8'd0, ERR_INCOMPLETE);
          n = n + 2'd1;
        end
      end
      mode_next      = M_FIND_NAME;
      esc_next       = 1'b0;
      prev_byte_next = 8'd0;
      level_next     = '0;
      held_next      = '0;
      halted_next    = 1'b0;
    end else if (!halted) begin
      if (mode == M_COMMENT) begin
        // only a newline leaves a comment; comments always start from find-name
        if (c == CH_NL) mode_next = M_FIND_NAME;
      end else if (esc) begin
        c        = esc_translate(items.byte_in);
        esc_next = 1'b0;
        do_text  = 1'b1;
      end else if (c == CH_SPACE || c == CH_TAB) begin
        if ((collapse && prev_byte == c) || mode == M_FIND_NAME || mode == M_FIND_VALUE) begin
          // skipped
        end else if (mode == M_READ_NAME) begin
          evs[n] = ev_make(EV_NAME_END, 8'd0, 8'd0, 1'b0);
          n = n + 2'd1;
          held_next = '0;
          mode_next = M_FIND_VALUE;
        end else if (trim && c == CH_SPACE) begin
          if (held < HELD_W'(MAX_HELD_SPACES)) held_next = held + 1'b1;
        end else begin
          do_text = 1'b1;
        end
      end else if (c == CH_HASH) begin
        do_close   = 1'b1;
        go_comment = 1'b1;
      end else if (c == CH_NL) begin
        if (mode == M_READ_NAME || mode == M_READ_VALUE) do_close = 1'b1;
      end else if (c == CH_OPEN) begin
        if (level >= LVL_W'(MAX_NESTING)) begin
          evs[n] = ev_make(EV_ERROR, 8'd0, 8'd0, ERR_BRACE);
          n = n + 2'd1;
          halted_next = 1'b1;
        end else if (mode == M_FIND_VALUE) begin
          level_next = level + 1'b1;
          mode_next  = M_FIND_NAME;
          evs[n] = ev_make(EV_NODE_BEGIN, 8'd0, 8'd0, 1'b0);
          n = n + 2'd1;
        end else if (mode == M_FIND_NAME && level == '0 && root_ok) begin
          level_next = level + 1'b1;
          evs[n] = ev_make(EV_NAME_END, 8'd0, 8'd0, 1'b0);
          n = n + 2'd1;
          evs[n] = ev_make(EV_NODE_BEGIN, 8'd0, 8'd0, 1'b0);
          n = n + 2'd1;
        end else begin
          evs[n] = ev_make(EV_ERROR, 8'd0, 8'd0, ERR_BRACE);
          n = n + 2'd1;
          halted_next = 1'b1;
        end
      end else if (c == CH_CLOSE) begin
        if (mode == M_READ_VALUE) begin
          evs[n] = ev_make(EV_VALUE_END, 8'd0, 8'd0, 1'b0);
          n = n + 2'd1;
          held_next = '0;
        end
        if ((mode != M_READ_VALUE && mode != M_FIND_NAME) || level == '0) begin
          evs[n] = ev_make(EV_ERROR, 8'd0, 8'd0, ERR_BRACE);
          n = n + 2'd1;
          halted_next = 1'b1;
        end else begin
          level_next = level - 1'b1;
          mode_next  = M_FIND_NAME;
          evs[n] = ev_make(EV_NODE_END, 8'd0, 8'd0, 1'b0);
          n = n + 2'd1;
        end
      end else if (c == CH_SEMI) begin
        if (mode != M_FIND_NAME) do_close = 1'b1;
      end else if (c == CH_BSLASH) begin
        esc_next = 1'b1;
      end else begin
        do_text = 1'b1;
      end

      if (do_close) begin
        if (mode == M_READ_NAME) begin
          evs[n] = ev_make(EV_NAME_END, 8'd0, 8'd0, 1'b0);
          n = n + 2'd1;
          evs[n] = ev_make(EV_VALUE_END, 8'd0, 8'd0, 1'b0);
          n = n + 2'd1;
        end else if (mode == M_READ_VALUE || mode == M_FIND_VALUE) begin
          evs[n] = ev_make(EV_VALUE_END, 8'd0, 8'd0, 1'b0);
          n = n + 2'd1;
        end
        held_next = '0;
        mode_next = M_FIND_NAME;
      end
      if (go_comment) mode_next = M_COMMENT;

      if (do_text) begin
        if (mode == M_FIND_NAME)       mode_next = M_READ_NAME;
        else if (mode == M_FIND_VALUE) mode_next = M_READ_VALUE;
        else                           mode_next = mode;
        evs[n] = ev_make((mode_next == M_READ_NAME) ? EV_NAME_BYTE : EV_VALUE_BYTE,
                         c, 8'(held), 1'b0);
        n = n + 2'd1;
        held_next = '0;
      end

      prev_byte_next = c;
    end
  end

  assign q_push       = accept && (n != 2'd0);
  assign q_data.count = n;
  assign q_data.ev    = evs;

  always_ff @(posedge clk) begin
    if (rst) begin
      collapse <= 1'b0;
      trim     <= 1'b0;
      root_ok  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_COLLAPSE: collapse <= cfg_data[0];
        CFG_TRIM:     trim     <= cfg_data[0];
        CFG_ROOT:     root_ok  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_FIND_NAME;
      esc       <= 1'b0;
      prev_byte <= 8'd0;
      level     <= '0;
      held      <= '0;
      halted    <= 1'b0;
    end else if (accept) begin
      mode      <= mode_next;
      esc       <= esc_next;
      prev_byte <= prev_byte_next;
      level     <= level_next;
      held      <= held_next;
      halted    <= halted_next;
    end
  end

endmodule

/* rtl/nct_queue.sv */
// ----------------------------------------------------------------------------
// nct_queue: short bundle queue between front and back
// Register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module nct_queue
  import nct_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output logic    full,
  output logic    not_empty,
  output bundle_t head
);

  bundle_t [QUEUE_DEPTH-1:0] slots;
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)   wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop)      count <= count + 1'b1;
      else if (!push && do_pop) count <= count - 1'b1;
    end
  end

endmodule

/* rtl/nct_back.sv */
// ----------------------------------------------------------------------------
// nct_back: event sequencer
// Holds one bundle in the output register and sends its events one word
// a cycle while the output is ready, marking the last one.
// ----------------------------------------------------------------------------
module nct_back
  import nct_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    q_not_empty,
  input  bundle_t q_head,
  output logic    q_pop,
  nct_out_if.source events
);

  bundle_t    cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       fire, last;
  evt_t       e;

  assign e    = cur.ev[idx];
  assign last = (idx == cur.count - 2'd1);
  assign fire = events.valid && events.ready;

  assign events.valid         = cur_valid;
  assign events.event_kind    = e.kind;
  assign events.text_byte     = e.text;
  assign events.spaces_before = e.spaces;
  assign events.error_code    = e.err;
  assign events.last_of_item  = last;

  assign q_pop = q_not_empty && (!cur_valid || (fire && last));

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (fire) begin
      if (last) begin
        cur_valid <= 1'b0;
        idx       <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

/* rtl/nested_config_text_tokenizer.sv */
// ----------------------------------------------------------------------------
// nested_config_text_tokenizer: byte-serial tokenizer for nested name/value text
// Front classifier, bundle queue and event sequencer.
// ----------------------------------------------------------------------------
// One byte is accepted every cycle while the two-entry bundle queue has room.
// A byte yields zero to three event words; the output sends one word a cycle
// while the consumer is ready, so the queue soaks up short bursts. With the
// output idle, the first word of a byte passes through a queue slot and then
// the output register. Configuration writes take effect on the next
// accepted byte.
module nested_config_text_tokenizer
  import nct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  nct_in_if.sink                items,
  nct_out_if.source             events,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic    q_push, q_pop, q_full, q_not_empty;
  bundle_t q_in, q_head;

  nct_front u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  nct_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  nct_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .events      (events)
  );

endmodule

/* rtl/nct_checker.sv */
// ----------------------------------------------------------------------------
// nct_port_checks: port-level checks on the tokenizer
// Bound to the top level; watches only its ports.
// ----------------------------------------------------------------------------
module nct_port_checks
  import nct_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] kind,
  input logic [7:0] text,
  input logic [7:0] spaces,
  input logic       err,
  input logic       last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({kind, text, spaces, err, last}))
    else $error("event word changed while stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

  // text bytes and errors are always the final word of their byte
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == EV_ERROR || kind == EV_NAME_BYTE || kind == EV_VALUE_BYTE)
    |-> last)
    else $error("text or error word not last of its byte");

  a_plain: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != EV_NAME_BYTE && kind != EV_VALUE_BYTE
    |-> text == 8'd0 && spaces == 8'd0)
    else $error("marker word carries text");

endmodule

bind nested_config_text_tokenizer nct_port_checks u_nct_port_checks (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (items.ready),
  .out_valid (events.valid),
  .out_ready (events.ready),
  .kind      (events.event_kind),
  .text      (events.text_byte),
  .spaces    (events.spaces_before),
  .err       (events.error_code),
  .last      (events.last_of_item)
);

/* test/nct_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nct_checker: event predictor and comparator for the config tokenizer
// Watches the byte, event and register ports. Keeps its own copy of the
// tokenizer state, queues the events each accepted byte should cause and
// matches every event word taken from the output against the oldest one.
// ----------------------------------------------------------------------------
module nct_checker
  import nct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  nct_in_if                     items,
  nct_out_if                    events,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           events_due,
  output int unsigned           mismatches
);

  typedef struct packed {
    evt_t ev;
    logic last;
  } due_event_t;

  due_event_t  due_events[$];
  int unsigned fail_count;

  logic       collapse_on;
  logic       trim_on;
  logic       root_on;

  mode_t      mode;
  mode_t      mode_saved;
  logic       esc;
  logic [7:0] prev_byte;
  logic [7:0] level;
  logic [7:0] held;
  logic       halted;

  task automatic clear_parse_state();
    mode       = M_FIND_NAME;
    mode_saved = M_FIND_NAME;
    esc        = 1'b0;
    prev_byte  = 8'h00;
    level      = 8'h00;
    held       = 8'h00;
    halted     = 1'b0;
  endtask

  task automatic note_event(kind_t k, logic [7:0] t, logic [7:0] s, logic e);
    due_event_t d;
    d.ev.kind   = k;
    d.ev.text   = t;
    d.ev.spaces = s;
    d.ev.err    = e;
    d.last      = 1'b0;
    due_events.push_back(d);
  endtask

  task automatic note_marker(kind_t k);
    note_event(k, 8'h00, 8'h00, 1'b0);
  endtask

  task automatic note_fault(logic code);
    note_event(EV_ERROR, 8'h00, 8'h00, code);
    halted = 1'b1;
  endtask

  // text byte; a find mode turns into the matching read mode
  task automatic emit_text(logic [7:0] c);
    if (mode == M_FIND_NAME) mode = M_READ_NAME;
    else if (mode == M_FIND_VALUE) mode = M_READ_VALUE;
    if (mode == M_READ_NAME) note_event(EV_NAME_BYTE, c, held, 1'b0);
    else note_event(EV_VALUE_BYTE, c, held, 1'b0);
    held = 8'h00;
  endtask

  task automatic end_token();
    if (mode == M_READ_NAME) begin
      note_marker(EV_NAME_END);
      note_marker(EV_VALUE_END);
    end else if (mode == M_READ_VALUE || mode == M_FIND_VALUE) begin
      note_marker(EV_VALUE_END);
    end
    held = 8'h00;
    mode = M_FIND_NAME;
  endtask

  task automatic tokenize_byte(input logic [7:0] b, input logic eod);
    logic [7:0] c;
    logic [7:0] last_b;
    int         queued_at_start;
    due_event_t tail;
    queued_at_start = due_events.size();
    c = b;
    if (eod) begin
      if (!halted) begin
        if (mode == M_READ_NAME) begin
          note_marker(EV_NAME_END);
          note_marker(EV_VALUE_END);
        end else if (mode == M_READ_VALUE) begin
          note_marker(EV_VALUE_END);
        end
        if (level != 0) note_event(EV_ERROR, 8'h00, 8'h00, ERR_INCOMPLETE);
      end
      clear_parse_state();
    end else if (!halted) begin
      last_b = prev_byte;
      if (mode == M_COMMENT) begin
        if (c == CH_NL) mode = mode_saved;
      end else if (esc) begin
        case (b)
          "n":     c = CH_NL;
          "r":     c = 8'h0D;
          "a":     c = 8'h07;
          "b":     c = 8'h08;
          "f":     c = 8'h0C;
          "t":     c = CH_TAB;
          default: c = b;
        endcase
        esc = 1'b0;
        emit_text(c);
      end else if (c == CH_SPACE || c == CH_TAB) begin
        if ((collapse_on && last_b == c) || mode == M_FIND_NAME || mode == M_FIND_VALUE) begin
          // blank dropped
        end else if (mode == M_READ_NAME) begin
          note_marker(EV_NAME_END);
          held = 8'h00;
          mode = M_FIND_VALUE;
        end else if (trim_on && c == CH_SPACE) begin
          if (held < MAX_HELD_SPACES) held = held + 8'd1;
        end else begin
          emit_text(c);
        end
      end else if (c == CH_HASH) begin
        end_token();
        mode_saved = mode;
        mode = M_COMMENT;
      end else if (c == CH_NL) begin
        if (mode == M_READ_NAME || mode == M_READ_VALUE) end_token();
      end else if (c == CH_OPEN) begin
        if (level >= MAX_NESTING) begin
          note_fault(ERR_BRACE);
        end else if (mode == M_FIND_VALUE) begin
          level = level + 8'd1;
          mode = M_FIND_NAME;
          note_marker(EV_NODE_BEGIN);
        end else if (mode == M_FIND_NAME && level == 0 && root_on) begin
          level = level + 8'd1;
          note_marker(EV_NAME_END);
          note_marker(EV_NODE_BEGIN);
        end else begin
          note_fault(ERR_BRACE);
        end
      end else if (c == CH_CLOSE) begin
        // an open value is closed before the brace is judged
        if (mode == M_READ_VALUE) begin
          note_marker(EV_VALUE_END);
          held = 8'h00;
        end
        if (mode != M_READ_VALUE && mode != M_FIND_NAME) begin
          note_fault(ERR_BRACE);
        end else if (level == 0) begin
          note_fault(ERR_BRACE);
        end else begin
          level = level - 8'd1;
          mode = M_FIND_NAME;
          note_marker(EV_NODE_END);
        end
      end else if (c == CH_SEMI) begin
        if (mode != M_FIND_NAME) end_token();
      end else if (c == CH_BSLASH) begin
        esc = 1'b1;
      end else begin
        emit_text(c);
      end
      prev_byte = c;
    end
    if (due_events.size() > queued_at_start) begin
      tail = due_events.pop_back();
      tail.last = 1'b1;
      due_events.push_back(tail);
    end
  endtask

  always @(posedge clk) begin
    due_event_t want;
    due_event_t got;
    if (rst) begin
      collapse_on = 1'b0;
      trim_on     = 1'b0;
      root_on     = 1'b0;
      clear_parse_state();
      due_events.delete();
      fail_count  = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_COLLAPSE: collapse_on = cfg_data[0];
          CFG_TRIM:     trim_on     = cfg_data[0];
          CFG_ROOT:     root_on     = cfg_data[0];
          default: ;
        endcase
      end
      if (items.valid && items.ready) tokenize_byte(items.byte_in, items.end_of_doc);
      if (events.valid && events.ready) begin
        got.ev.kind   = kind_t'(events.event_kind);
        got.ev.text   = events.text_byte;
        got.ev.spaces = events.spaces_before;
        got.ev.err    = events.error_code;
        got.last      = events.last_of_item;
        if (due_events.size() == 0) begin
          $display("%0t: unexpected event word kind=%0d text=%02h spaces=%0d err=%0b last=%0b",
                   $time, got.ev.kind, got.ev.text, got.ev.spaces, got.ev.err, got.last);
          fail_count++;
        end else begin
          want = due_events.pop_front();
          if (got !== want) begin
            $display("%0t: event mismatch: expected kind=%0d text=%02h spaces=%0d err=%0b last=%0b",
                     $time, want.ev.kind, want.ev.text, want.ev.spaces, want.ev.err, want.last);
            $display("%0t:                 actual   kind=%0d text=%02h spaces=%0d err=%0b last=%0b",
                     $time, got.ev.kind, got.ev.text, got.ev.spaces, got.ev.err, got.last);
            fail_count++;
          end
        end
      end
    end
    events_due <= due_events.size();
    mismatches <= fail_count;
  end

endmodule

/* test/tb_nested_config_text_tokenizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nested_config_text_tokenizer: stimulus and verdict for the tokenizer
// Directed documents first, then random documents under four input-gap and
// back-pressure regimes and four register settings, plus a nesting run left open at the
// end and a blank run. The checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module tb_nested_config_text_tokenizer;
  import nct_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 8;
  localparam int PHASE_BYTES  = 30;
  localparam int NEST_DEPTH   = 6;
  localparam int BLANK_RUN    = 20;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned events_due;
  int unsigned mismatches;
  int unsigned cycle_count = 0;
  int unsigned bytes_taken = 0;
  int          gap_pct     = 0;
  int          stall_pct   = 0;
  int          noise_pct   = 0;

  nct_in_if  items_ch ();
  nct_out_if events_ch ();

  nested_config_text_tokenizer dut (
    .clk       (clk),
    .rst       (rst),
    .items     (items_ch),
    .events    (events_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  nct_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .items      (items_ch),
    .events     (events_ch),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .events_due (events_due),
    .mismatches (mismatches)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    events_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // valid stays high across back-to-back words
  task automatic send_word(input logic [7:0] b, input logic eod);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      items_ch.valid <= 1'b0;
      @(posedge clk);
    end
    items_ch.valid      <= 1'b1;
    items_ch.byte_in    <= b;
    items_ch.end_of_doc <= eod;
    do @(posedge clk); while (!items_ch.ready);
    bytes_taken++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic send_eod();
    send_word(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic put_byte(input logic [7:0] b);
    if (noise_pct != 0 && $urandom_range(99) < noise_pct) send_word(8'($urandom_range(255)), 1'b0);
    else send_word(b, 1'b0);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    if ($urandom_range(99) < 60) return 8'($urandom_range(8'h61, 8'h7A));
    do begin
      c = 8'($urandom_range(255));
    end while (c == CH_SPACE || c == CH_TAB || c == CH_HASH || c == CH_OPEN ||
               c == CH_CLOSE || c == CH_SEMI || c == CH_BSLASH || c == CH_NL);
    return c;
  endfunction

  task automatic put_blanks();
    repeat ($urandom_range(1, 3)) put_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
  endtask

  task automatic put_token(input bit in_value, input int max_len);
    string esc_letters;
    int    r;
    esc_letters = "nrabft";
    repeat ($urandom_range(1, max_len)) begin
      r = $urandom_range(99);
      if (r < 12) begin
        put_byte(CH_BSLASH);
        if ($urandom_range(1)) put_byte(esc_letters[$urandom_range(5)]);
        else put_byte(8'($urandom_range(255)));
      end else if (in_value && r < 30) begin
        repeat ($urandom_range(1, 3)) put_byte($urandom_range(3) != 0 ? CH_SPACE : CH_TAB);
      end else begin
        put_byte(plain_char());
      end
    end
  endtask

  // mostly well-formed documents; a few carry corrupted words
  task automatic make_doc();
    int depth;
    int r;
    noise_pct = ($urandom_range(99) < 15) ? 8 : 0;
    depth = 0;
    if ($urandom_range(99) < 25) begin
      put_byte(CH_OPEN);
      depth = 1;
    end
    repeat ($urandom_range(2, 10)) begin
      r = $urandom_range(99);
      if (r < 15 && depth > 0) begin
        put_byte(CH_CLOSE);
        depth--;
      end else if (r < 30 && depth < 5) begin
        put_token(1'b0, 5);
        put_blanks();
        put_byte(CH_OPEN);
        depth++;
      end else if (r < 38) begin
        put_byte(CH_HASH);
        repeat ($urandom_range(0, 4)) put_byte(plain_char());
        put_byte(CH_NL);
      end else begin
        put_token(1'b0, 5);
        put_blanks();
        if ($urandom_range(99) < 85) put_token(1'b1, 8);
        if ($urandom_range(99) < 20) put_blanks();
        case ($urandom_range(2))
          0: put_byte(CH_SEMI);
          1: put_byte(CH_NL);
          default: begin
            if (depth > 0) begin
              put_byte(CH_CLOSE);
              depth--;
            end else begin
              put_byte(CH_SEMI);
            end
          end
        endcase
      end
    end
    if ($urandom_range(99) < 75) repeat (depth) put_byte(CH_CLOSE);
    noise_pct = 0;
    send_eod();
  endtask

  task automatic deep_nest_doc();
    repeat (NEST_DEPTH) begin
      send_word(plain_char(), 1'b0);
      send_word(CH_SPACE, 1'b0);
      send_word(CH_OPEN, 1'b0);
    end
    // left open: the end of the document reports it
    send_text("x y");
    send_eod();
  endtask

  task automatic blank_run_doc();
    send_text("k v");
    repeat (BLANK_RUN) send_word(CH_SPACE, 1'b0);
    send_text("w;");
    send_eod();
  endtask

  task automatic wait_idle();
    items_ch.valid <= 1'b0;
    do @(posedge clk); while (events_due != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  task automatic set_config(input logic collapse, input logic trim, input logic root);
    wait_idle();
    write_reg(CFG_COLLAPSE, collapse);
    write_reg(CFG_TRIM, trim);
    write_reg(CFG_ROOT, root);
    cfg_write <= 1'b0;
  endtask

  task automatic random_phase(input int gap, input int stall);
    int unsigned start;
    gap_pct   = gap;
    stall_pct = stall;
    start = bytes_taken;
    while (bytes_taken - start < PHASE_BYTES) make_doc();
  endtask

  initial begin
    items_ch.valid      = 1'b0;
    items_ch.byte_in    = 8'h00;
    items_ch.end_of_doc = 1'b0;
    events_ch.ready     = 1'b1;
    cfg_write           = 1'b0;
    cfg_index           = CFG_COLLAPSE;
    cfg_data            = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // plain settings: every event kind, escapes, comment, stray close brace
    set_config(1'b0, 1'b0, 1'b0);
    send_word(8'hFF, 1'b0);
    send_text(" \n{");
    send_word(8'h00, 1'b0);
    send_text("\t\\n#}\nq;}}x");
    send_eod();

    // nameless root, collapse after an escaped space, held blanks dropped
    set_config(1'b1, 1'b1, 1'b1);
    send_text("{a\\  \tv  w }");
    send_eod();
    send_text("{x");
    send_eod();

    set_config(1'b0, 1'b0, 1'b0);
    random_phase(0, 0);
    deep_nest_doc();

    set_config(1'b1, 1'b0, 1'b1);
    random_phase(87, 0);

    set_config(1'b0, 1'b1, 1'b0);
    random_phase(0, 87);
    blank_run_doc();

    set_config(1'b1, 1'b1, 1'b1);
    random_phase(13, 13);

    wait_idle();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
